// ===== rtl/core/gwf_pkg.sv =====
// ----------------------------------------------------------------------------
// gwf_pkg: shared types and constants for the grid wall follower
// Grid geometry, opcodes, status codes, headings and item structs.
// ----------------------------------------------------------------------------
package gwf_pkg;

	localparam int GRID_ROWS = 16;
	localparam int GRID_COLS = 16;
	localparam int CELLS     = GRID_ROWS * GRID_COLS;
	localparam int ADDR_W    = $clog2(CELLS);

	// opcodes
	localparam logic [1:0] OP_WRITE   = 2'd0;
	localparam logic [1:0] OP_RESTART = 2'd1;
	localparam logic [1:0] OP_STEP    = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	// status codes
	localparam logic [2:0] ST_DONE   = 3'd0;
	localparam logic [2:0] ST_MOVED  = 3'd1;
	localparam logic [2:0] ST_EXITED = 3'd2;
	localparam logic [2:0] ST_BACK   = 3'd3;
	localparam logic [2:0] ST_STUCK  = 3'd4;

	// headings
	localparam logic [1:0] DIR_DOWN  = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP    = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_START_ROW     = 2'd0;
	localparam logic [1:0] REG_START_COL     = 2'd1;
	localparam logic [1:0] REG_FIRST_HEADING = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [3:0] cell_row;
		logic [3:0] cell_col;
		logic       cell_open;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] pos_row;
		logic [3:0] pos_col;
		logic [1:0] search_heading;
	} rsp_t;

	// single-port grid store access
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic              wdata;
	} gwf_mem_req_t;

	function automatic logic in_grid(input logic [4:0] r, input logic [4:0] c);
		return (int'(r) < GRID_ROWS) && (int'(c) < GRID_COLS);
	endfunction

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [4:0] r,
	                                                input logic [4:0] c);
		return ADDR_W'(int'(r) * GRID_COLS + int'(c));
	endfunction

endpackage

// ===== rtl/core/gwf_grid.sv =====
// ----------------------------------------------------------------------------
// gwf_grid: single-port grid cell store
// One bit per cell, one access a cycle, registered read. A per-cell valid
// bit cleared by reset makes unwritten cells read as wall.
// ----------------------------------------------------------------------------
module gwf_grid
	import gwf_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  gwf_mem_req_t mem,
	output logic         rd_open
);

	logic             mem_q [CELLS];
	logic [CELLS-1:0] valid_q;
	logic             rd_bit_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (mem.en && mem.we) begin
			mem_q[mem.addr] <= mem.wdata;
		end else if (mem.en) begin
			rd_bit_q <= mem_q[mem.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else if (mem.en && mem.we) begin
			valid_q[mem.addr] <= 1'b1;
		end else if (mem.en) begin
			rd_valid_q <= valid_q[mem.addr];
		end
	end

	assign rd_open = rd_bit_q & rd_valid_q;

endmodule

// ===== rtl/core/grid_wall_follower_unit.sv =====
// ----------------------------------------------------------------------------
// grid_wall_follower_unit: right-hand wall follower on a 16 x 16 grid
// Grid loader, walker restart and single-step engine behind one item channel.
// ----------------------------------------------------------------------------
// Each request item gives exactly one response item. One item is worked on at
// a time. A grid write, a restart or an unused opcode goes from acceptance
// straight to the response state, which loads the response register once it
// is free; so does a step that ends the walk at once. A step that searches
// probes up to four neighbors: an in-grid neighbor through a read issue state
// and a check of the registered read data from the single-port grid store, a
// neighbor off the grid through the issue state only. The grid reads as all
// walls after reset with no clearing pass: each cell has a valid bit cleared
// by reset. A new request item is taken while the previous response still
// waits in the output register. Configuration writes land at once; start
// row/column/heading are placed at the next restart, while the start-cell
// tests of a step always use the current register values.
// ----------------------------------------------------------------------------
module grid_wall_follower_unit
	import gwf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	// request channel
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req,
	// response channel
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	// sequencer states
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ISSUE = 2'd1; // pick a probe direction, read the cell
	localparam logic [1:0] S_CHECK = 2'd2; // cell value is back
	localparam logic [1:0] S_EMIT  = 2'd3; // load the response register

	logic [1:0] state_q;
	logic [1:0] probe_k_q;
	logic [2:0] status_q;

	// configuration
	logic [3:0] start_row_q;
	logic [3:0] start_col_q;
	logic [1:0] first_heading_q;

	// walker
	logic [3:0] walker_row_q;
	logic [3:0] walker_col_q;
	logic [1:0] heading_q;
	logic       left_start_q;
	logic       walk_over_q;

	// probe in flight
	logic [3:0] cand_row_q;
	logic [3:0] cand_col_q;
	logic [1:0] cand_dir_q;

	logic       rsp_valid_q;
	rsp_t       rsp_q;

	gwf_mem_req_t mem;
	logic         rd_open;

	logic       req_take;
	logic       rsp_free;
	logic       on_edge;
	logic       at_start;
	logic [2:0] end_status;
	logic [1:0] dir;
	logic [4:0] cand_r;
	logic [4:0] cand_c;
	logic       dir_ok;
	logic       probe_ok;

	assign req_stall = (state_q != S_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;

	// end-of-walk test on the current cell
	always_comb begin
		on_edge  = in_grid({1'b0, walker_row_q}, {1'b0, walker_col_q}) &&
		           (walker_row_q == 4'd0 || int'(walker_row_q) == GRID_ROWS - 1 ||
		            walker_col_q == 4'd0 || int'(walker_col_q) == GRID_COLS - 1);
		at_start = (walker_row_q == start_row_q) && (walker_col_q == start_col_q);
		priority if (on_edge && !at_start) begin
			end_status = ST_EXITED;
		end else if (at_start && left_start_q) begin
			end_status = ST_BACK;
		end else begin
			end_status = ST_MOVED;
		end
	end

	// neighbor for the current probe; heading order wraps down, right, up, left
	always_comb begin
		dir    = heading_q + probe_k_q;
		cand_r = {1'b0, walker_row_q};
		cand_c = {1'b0, walker_col_q};
		dir_ok = 1'b1;
		unique case (dir)
			DIR_DOWN: begin
				cand_r = {1'b0, walker_row_q} + 5'd1;
			end
			DIR_RIGHT: begin
				cand_c = {1'b0, walker_col_q} + 5'd1;
			end
			DIR_UP: begin
				dir_ok = (walker_row_q != 4'd0);
				cand_r = {1'b0, walker_row_q} - 5'd1;
			end
			DIR_LEFT: begin
				dir_ok = (walker_col_q != 4'd0);
				cand_c = {1'b0, walker_col_q} - 5'd1;
			end
			default: begin
				dir_ok = 1'b0;
			end
		endcase
		probe_ok = dir_ok && in_grid(cand_r, cand_c);
	end

	// grid port: writes from idle, reads from the probe state
	always_comb begin
		mem = '0;
		if (state_q == S_IDLE) begin
			mem.en    = req_take && (req.opcode == OP_WRITE) &&
			            in_grid({1'b0, req.cell_row}, {1'b0, req.cell_col});
			mem.we    = 1'b1;
			mem.addr  = cell_addr({1'b0, req.cell_row}, {1'b0, req.cell_col});
			mem.wdata = req.cell_open;
		end else if (state_q == S_ISSUE) begin
			mem.en   = probe_ok;
			mem.we   = 1'b0;
			mem.addr = cell_addr(cand_r, cand_c);
		end
	end

	gwf_grid u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.mem     (mem),
		.rd_open (rd_open)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q     <= 4'd0;
			start_col_q     <= 4'd0;
			first_heading_q <= DIR_RIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_ROW:     start_row_q     <= cfg_data;
				REG_START_COL:     start_col_q     <= cfg_data;
				REG_FIRST_HEADING: first_heading_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// probe payload, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_ISSUE) begin
			cand_row_q <= cand_r[3:0];
			cand_col_q <= cand_c[3:0];
			cand_dir_q <= dir;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			probe_k_q    <= 2'd0;
			status_q     <= ST_DONE;
			walker_row_q <= 4'd0;
			walker_col_q <= 4'd0;
			heading_q    <= DIR_RIGHT;
			left_start_q <= 1'b0;
			walk_over_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_take) begin
						if (req.opcode == OP_STEP && !walk_over_q &&
						    end_status == ST_MOVED) begin
							// live walk, not at an end cell: search the neighbors
							left_start_q <= 1'b1;
							probe_k_q    <= 2'd0;
							state_q      <= S_ISSUE;
						end else begin
							state_q <= S_EMIT;
							if (req.opcode == OP_RESTART) begin
								status_q     <= ST_DONE;
								walker_row_q <= start_row_q;
								walker_col_q <= start_col_q;
								heading_q    <= first_heading_q;
								left_start_q <= 1'b0;
								walk_over_q  <= 1'b0;
							end else if (req.opcode == OP_STEP) begin
								if (walk_over_q) begin
									status_q <= (end_status == ST_MOVED) ?
									            ST_STUCK : end_status;
								end else begin
									walk_over_q <= 1'b1;
									status_q    <= end_status;
								end
							end else begin
								status_q <= ST_DONE;
							end
						end
					end
				end
				S_ISSUE: begin
					if (probe_ok) begin
						state_q <= S_CHECK;
					end else if (probe_k_q == 2'd3) begin
						walk_over_q <= 1'b1;
						status_q    <= ST_STUCK;
						state_q     <= S_EMIT;
					end else begin
						probe_k_q <= probe_k_q + 2'd1;
					end
				end
				S_CHECK: begin
					if (rd_open) begin
						walker_row_q <= cand_row_q;
						walker_col_q <= cand_col_q;
						heading_q    <= cand_dir_q + 2'd3;
						status_q     <= ST_MOVED;
						state_q      <= S_EMIT;
					end else if (probe_k_q == 2'd3) begin
						walk_over_q <= 1'b1;
						status_q    <= ST_STUCK;
						state_q     <= S_EMIT;
					end else begin
						probe_k_q <= probe_k_q + 2'd1;
						state_q   <= S_ISSUE;
					end
				end
				S_EMIT: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && rsp_free) begin
			rsp_q.status         <= status_q;
			rsp_q.pos_row        <= walker_row_q;
			rsp_q.pos_col        <= walker_col_q;
			rsp_q.search_heading <= heading_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// read data is only examined right after a read was issued
	a_check_after_issue: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHECK |-> $past(state_q) == S_ISSUE)
		else $error("probe check without a preceding read");

	// items other than steps go straight to the response stage
	a_nonstep_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.opcode != OP_STEP) |=> state_q == S_EMIT)
		else $error("non-step item did not head for the response stage");

	// the walk only ends together with a step response
	a_walk_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(walk_over_q) |-> state_q == S_EMIT)
		else $error("walk ended without a response being prepared");

endmodule
